>>> rtl/core/wwht_pkg.sv
// ----------------------------------------------------------------------------
// wwht_pkg
// Shared types and constants for the whitespace word hash tokenizer.
// ----------------------------------------------------------------------------
package wwht_pkg;

  localparam int BYTE_W  = 8;
  localparam int TOKEN_W = 16;
  localparam int COUNT_W = 6;
  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = 24;

  localparam logic [TOKEN_W-1:0] HASH_SEED = 16'd5381;
  localparam logic [BYTE_W-1:0]  CHAR_SPACE = 8'h20;
  localparam logic [BYTE_W-1:0]  CHAR_TAB   = 8'h09;
  localparam logic [BYTE_W-1:0]  CHAR_LF    = 8'h0A;
  localparam logic [BYTE_W-1:0]  CHAR_NUL   = 8'h00;

  typedef struct packed {
    logic byte_step;  // accepted input word
    logic close;      // close open word at end of text
    logic pad;        // emit one padding token
    logic clear;      // return to idle state for next transcript
  } cmd_t;

  typedef struct packed {
    logic out_free;      // output register can be loaded this cycle
    logic word_pending;  // open word that will produce a token
    logic last_slot;     // next loaded result is the final one
    logic slots_full;    // all result slots used
  } stat_t;

endpackage

>>> rtl/core/wwht_ctrl.sv
// ----------------------------------------------------------------------------
// wwht_ctrl
// Sequencer: byte intake, end-of-text word close and zero padding.
// ----------------------------------------------------------------------------
module wwht_ctrl
  import wwht_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  input  logic  in_last,
  output logic  in_ready,
  input  stat_t stat,
  output cmd_t  cmd
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_CLOSE = 2'd1;
  localparam logic [1:0] S_PAD   = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready      = stat.out_free;
        cmd.byte_step = in_valid && stat.out_free;
        if (cmd.byte_step && in_last) begin
          state_next = S_CLOSE;
        end
      end
      S_CLOSE: begin
        if (stat.word_pending) begin
          if (stat.out_free) begin
            cmd.close = 1'b1;
            if (stat.last_slot) begin
              cmd.clear  = 1'b1;
              state_next = S_IDLE;
            end else begin
              state_next = S_PAD;
            end
          end
        end else begin
          cmd.close = 1'b1;
          if (stat.slots_full) begin
            cmd.clear  = 1'b1;
            state_next = S_IDLE;
          end else begin
            state_next = S_PAD;
          end
        end
      end
      S_PAD: begin
        if (stat.slots_full) begin
          cmd.clear  = 1'b1;
          state_next = S_IDLE;
        end else if (stat.out_free) begin
          cmd.pad = 1'b1;
          if (stat.last_slot) begin
            cmd.clear  = 1'b1;
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

>>> rtl/core/wwht_dp.sv
// ----------------------------------------------------------------------------
// wwht_dp
// Datapath: djb2 word hash, counters and output word register.
// ----------------------------------------------------------------------------
module wwht_dp
  import wwht_pkg::*;
#(
  parameter int MAX_TOKENS = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  cmd_t               cmd,
  input  logic [BYTE_W-1:0]  text_byte,
  output stat_t              stat,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [TOKEN_W-1:0] token_id,
  output logic               is_padding,
  output logic [COUNT_W-1:0] token_count,
  output logic               last_result
);

  localparam int CW = $clog2(MAX_TOKENS + 1);
  localparam logic [CW-1:0] MAX_C     = CW'(MAX_TOKENS);
  localparam logic [CW-1:0] LAST_C    = CW'(MAX_TOKENS - 1);
  localparam logic [CW-1:0] BYTE_LIM  = CW'(MAX_TOKENS - 1);
  localparam logic [CW-1:0] ONE_C     = CW'(1);

  logic [TOKEN_W-1:0] word_hash, word_hash_next;
  logic               inside_word, inside_word_next;
  logic [CW-1:0]      tokens_emitted, tokens_emitted_next;
  logic [CW-1:0]      bytes_seen, bytes_seen_next;
  logic [CW-1:0]      slot, slot_next;
  logic               text_stopped, text_stopped_next;

  logic               is_sep;
  logic               take;
  logic               tok_room;
  logic               sep_emit;
  logic               close_emit;
  logic               load;
  logic               last_load;
  logic [CW-1:0]      count_total;
  logic [TOKEN_W-1:0] hash_step;
  logic               out_free;

  assign out_free  = !out_valid || out_ready;
  assign is_sep    = (text_byte == CHAR_SPACE) || (text_byte == CHAR_TAB) ||
                     (text_byte == CHAR_LF);
  assign take      = cmd.byte_step && !text_stopped && (text_byte != CHAR_NUL) &&
                     (bytes_seen < BYTE_LIM);
  assign tok_room  = tokens_emitted < MAX_C;
  assign sep_emit  = take && is_sep && inside_word && tok_room;
  assign close_emit = cmd.close && inside_word && tok_room;
  assign load      = sep_emit || close_emit || cmd.pad;
  assign last_load = !sep_emit && (slot == LAST_C);
  assign count_total = close_emit ? tokens_emitted + ONE_C : tokens_emitted;
  assign hash_step = (word_hash << 5) + word_hash + {{(TOKEN_W-BYTE_W){1'b0}}, text_byte};

  assign stat.out_free     = out_free;
  assign stat.word_pending = inside_word && tok_room;
  assign stat.last_slot    = slot == LAST_C;
  assign stat.slots_full   = slot >= MAX_C;

  always_comb begin
    word_hash_next      = word_hash;
    inside_word_next    = inside_word;
    tokens_emitted_next = tokens_emitted;
    bytes_seen_next     = bytes_seen;
    slot_next           = slot;
    text_stopped_next   = text_stopped;
    if (cmd.byte_step && !text_stopped && (text_byte == CHAR_NUL)) begin
      text_stopped_next = 1'b1;
    end
    if (take) begin
      bytes_seen_next = bytes_seen + ONE_C;
      if (is_sep) begin
        inside_word_next = 1'b0;
        word_hash_next   = HASH_SEED;
      end else begin
        inside_word_next = 1'b1;
        word_hash_next   = hash_step;
      end
    end
    if (cmd.close) begin
      inside_word_next = 1'b0;
      word_hash_next   = HASH_SEED;
    end
    if (sep_emit || close_emit) begin
      tokens_emitted_next = tokens_emitted + ONE_C;
    end
    if (load) begin
      slot_next = slot + ONE_C;
    end
    if (cmd.clear) begin
      word_hash_next      = HASH_SEED;
      inside_word_next    = 1'b0;
      tokens_emitted_next = '0;
      bytes_seen_next     = '0;
      slot_next           = '0;
      text_stopped_next   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      word_hash      <= HASH_SEED;
      inside_word    <= 1'b0;
      tokens_emitted <= '0;
      bytes_seen     <= '0;
      slot           <= '0;
      text_stopped   <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      word_hash      <= word_hash_next;
      inside_word    <= inside_word_next;
      tokens_emitted <= tokens_emitted_next;
      bytes_seen     <= bytes_seen_next;
      slot           <= slot_next;
      text_stopped   <= text_stopped_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // final result carries the real token total
  always_ff @(posedge clk) begin
    if (load) begin
      token_id    <= cmd.pad ? '0 : word_hash;
      is_padding  <= cmd.pad;
      last_result <= last_load;
      token_count <= last_load ? COUNT_W'(count_total) : '0;
    end
  end

endmodule

>>> rtl/core/whitespace_word_hash_tokenizer_top.sv
// ----------------------------------------------------------------------------
// whitespace_word_hash_tokenizer_top
// Splits a byte stream into words and emits a djb2 16-bit hash per word.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream: one text byte per word in s_tdata[7:0], s_tlast on the
//   final byte of a transcript. Space, tab and newline separate words.
//   Output stream: one token per word; m_tdata holds the token id and, on
//   the final result, the real token count; m_tuser flags padding; m_tlast
//   marks the final result. Every transcript yields MAX_TOKENS results.
//   Throughput: one input byte per cycle while the output register drains.
//   A separator that ends a word loads its token on the byte's accepting
//   edge; it is on m_tdata the cycle after.
//   After s_tlast the sequencer closes the open word, then emits the
//   padding results; input is held off until the last result has been
//   loaded. Only the first MAX_TOKENS-1 bytes are used and a zero byte
//   ends the text; later bytes are consumed and ignored.
//   Stall: a low m_tready freezes the output register and deasserts
//   s_tready until the register frees up.
//   Reset (rst, synchronous): clears hash, counters and valid; the block
//   comes out ready for a new transcript.
// ----------------------------------------------------------------------------
module whitespace_word_hash_tokenizer_top
  import wwht_pkg::*;
#(
  parameter int MAX_TOKENS = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,   // [7:0] text_byte
  input  logic                  s_tlast,   // end_of_text
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,   // [15:0] token_id, [21:16] token_count
  output logic                  m_tuser,   // [0] is_padding
  output logic                  m_tlast    // last_result
);

  cmd_t               cmd;
  stat_t              stat;
  logic [TOKEN_W-1:0] token_id;
  logic [COUNT_W-1:0] token_count;

  wwht_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_last  (s_tlast),
    .in_ready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  wwht_dp #(
    .MAX_TOKENS (MAX_TOKENS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .text_byte   (s_tdata[BYTE_W-1:0]),
    .stat        (stat),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .token_id    (token_id),
    .is_padding  (m_tuser),
    .token_count (token_count),
    .last_result (m_tlast)
  );

  assign m_tdata = {{(OUT_DATA_W-TOKEN_W-COUNT_W){1'b0}}, token_count, token_id};

endmodule

>>> test/whitespace_word_hash_tokenizer_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// whitespace_word_hash_tokenizer_top_tb
// Streams transcripts through the tokenizer and checks every token word
// against a cycle-free predictor of the word hashes, padding, count and last flag.
// ----------------------------------------------------------------------------
module whitespace_word_hash_tokenizer_top_tb;
  import wwht_pkg::*;

  localparam int MAX_TOKENS  = 32;
  localparam int STALL_LIMIT = 4000;
  localparam int HOLD_CYCLES = 300;

  typedef struct packed {
    logic [BYTE_W-1:0] text;
    logic              eot;
  } text_item_t;

  typedef struct packed {
    logic [TOKEN_W-1:0] id;
    logic               pad;
    logic [COUNT_W-1:0] count;
    logic               last;
  } token_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  logic                  s_tlast = 1'b0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  m_tuser;
  logic                  m_tlast;

  text_item_t text_q[$];
  token_t     token_q[$];

  int send_idle = 18;
  int recv_idle = 60;
  int errors = 0;
  int tokens_seen = 0;
  int items_added = 0;
  int stall_cycles = 0;
  int hold_left = 0;
  logic hold_start = 1'b0;

  // predictor state
  logic [TOKEN_W-1:0] word_hash = HASH_SEED;
  logic               in_word = 1'b0;
  int                 tokens_out = 0;
  int                 bytes_used = 0;
  logic               stopped = 1'b0;

  whitespace_word_hash_tokenizer_top #(
    .MAX_TOKENS(MAX_TOKENS)
  ) i_dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tlast (s_tlast),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser),
    .m_tlast (m_tlast)
  );

  always #4 clk = ~clk;

  function automatic logic is_sep(logic [BYTE_W-1:0] b);
    return b == CHAR_SPACE || b == CHAR_TAB || b == CHAR_LF;
  endfunction

  function automatic void clear_tokenizer();
    word_hash  = HASH_SEED;
    in_word    = 1'b0;
    tokens_out = 0;
    bytes_used = 0;
    stopped    = 1'b0;
  endfunction

  function automatic void close_word(ref token_t step_q[$]);
    token_t t;
    if (in_word) begin
      if (tokens_out < MAX_TOKENS) begin
        t = '{id: word_hash, pad: 1'b0, count: '0, last: 1'b0};
        step_q.push_back(t);
        tokens_out++;
      end
      in_word   = 1'b0;
      word_hash = HASH_SEED;
    end
  endfunction

  function automatic void tokenize_byte(logic [BYTE_W-1:0] b, logic eot);
    token_t step_q[$];
    token_t t;
    int     real_tokens;
    if (!stopped) begin
      if (b == CHAR_NUL) begin
        stopped = 1'b1;
      end else if (bytes_used < MAX_TOKENS - 1) begin
        bytes_used++;
        if (is_sep(b)) begin
          close_word(step_q);
        end else begin
          word_hash = word_hash * 16'd33 + {8'h00, b};
          in_word   = 1'b1;
        end
      end
    end
    if (eot) begin
      close_word(step_q);
      real_tokens = tokens_out;
      for (int i = tokens_out; i < MAX_TOKENS; i++) begin
        t = '{id: '0, pad: 1'b1, count: '0, last: 1'b0};
        step_q.push_back(t);
      end
      if (step_q.size() > 0) begin
        t = step_q.pop_back();
        t.count = real_tokens[COUNT_W-1:0];
        t.last  = 1'b1;
        step_q.push_back(t);
      end
      clear_tokenizer();
    end
    foreach (step_q[i]) token_q.push_back(step_q[i]);
  endfunction

  task automatic report_mismatch(string what, int unsigned want, int unsigned got);
    if (errors < 40)
      $display("ERROR %0t ns: token word %0d %s: expected %0h, got %0h",
               $realtime, tokens_seen, what, want, got);
    errors++;
  endtask

  // driver
  always @(posedge clk) begin
    text_item_t it;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || s_tready) begin
      if (s_tvalid) tokenize_byte(s_tdata, s_tlast);
      if (text_q.size() > 0 && $urandom_range(99) >= send_idle) begin
        it = text_q.pop_front();
        s_tdata  <= it.text;
        s_tlast  <= it.eot;
        s_tvalid <= 1'b1;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // long receiver hold-off
  always @(posedge clk) begin
    if (hold_start) hold_left <= HOLD_CYCLES;
    else if (hold_left != 0) hold_left <= hold_left - 1;
  end

  // monitor
  always @(posedge clk) begin
    token_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (token_q.size() == 0) begin
          report_mismatch("unexpected word", 0, m_tdata);
        end else begin
          want = token_q.pop_front();
          if (m_tdata[TOKEN_W-1:0] != want.id)
            report_mismatch("token_id", want.id, m_tdata[TOKEN_W-1:0]);
          if (m_tdata[TOKEN_W +: COUNT_W] != want.count)
            report_mismatch("token_count", want.count, m_tdata[TOKEN_W +: COUNT_W]);
          if (m_tuser != want.pad)
            report_mismatch("is_padding", want.pad, m_tuser);
          if (m_tlast != want.last)
            report_mismatch("last_result", want.last, m_tlast);
        end
        tokens_seen++;
      end
      m_tready <= (hold_left == 0) && ($urandom_range(99) >= recv_idle);
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // stimulus
  function automatic void push_text(logic [BYTE_W-1:0] b, logic eot);
    text_q.push_back('{text: b, eot: eot});
    items_added++;
  endfunction

  function automatic void push_transcript(logic [BYTE_W-1:0] bytes[$]);
    foreach (bytes[i]) push_text(bytes[i], i == bytes.size() - 1);
  endfunction

  function automatic logic [BYTE_W-1:0] pick_letter();
    logic [BYTE_W-1:0] b;
    do b = BYTE_W'($urandom_range(1, 255)); while (is_sep(b));
    return b;
  endfunction

  function automatic logic [BYTE_W-1:0] pick_sep();
    case ($urandom_range(2))
      0:       return CHAR_SPACE;
      1:       return CHAR_TAB;
      default: return CHAR_LF;
    endcase
  endfunction

  function automatic void add_random_transcript();
    logic [BYTE_W-1:0] bytes[$];
    int len;
    len = ($urandom_range(4) == 0) ? $urandom_range(31, 45) : $urandom_range(1, 30);
    if ($urandom_range(9) == 0) begin
      // noise, zero bytes included
      repeat (len) bytes.push_back(BYTE_W'($urandom_range(255)));
    end else begin
      while (bytes.size() < len) begin
        repeat ($urandom_range(1, 7)) bytes.push_back(pick_letter());
        if ($urandom_range(24) == 0) bytes.push_back(CHAR_NUL);
        repeat ($urandom_range(0, 3)) bytes.push_back(pick_sep());
      end
    end
    push_transcript(bytes);
  endfunction

  function automatic void add_directed();
    // two words, consecutive separators, eot closes the open word
    push_transcript('{8'hFF, 8'h7F, CHAR_SPACE, CHAR_TAB, CHAR_LF, 8'h01, 8'h80});
    // empty text: zero byte carrying eot, all padding
    push_transcript('{CHAR_NUL});
    // eot on a separator
    push_transcript('{8'h61, CHAR_SPACE});
    // zero byte stops the text mid-word, later bytes ignored
    push_transcript('{8'h62, CHAR_NUL, 8'h63, CHAR_SPACE, 8'h64});
    // single letter with eot
    push_transcript('{8'h55});
    // single separator with eot
    push_transcript('{CHAR_TAB});
  endfunction

  function automatic void add_byte_limit_text();
    logic [BYTE_W-1:0] bytes[$];
    // short words past the byte limit, then a long word that a separator closes
    for (int i = 0; i < 40; i++)
      bytes.push_back((i % 2 == 0) ? BYTE_W'(8'h41 + i) : CHAR_SPACE);
    push_transcript(bytes);
    bytes.delete();
    repeat (28) bytes.push_back(pick_letter());
    repeat (8) bytes.push_back(pick_sep());
    push_transcript(bytes);
  endfunction

  initial begin
    add_directed();
    add_byte_limit_text();
    while (items_added < 120) add_random_transcript();
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    while (text_q.size() != 0) @(negedge clk);
    send_idle = 60;
    recv_idle = 18;
    while (items_added < 240) add_random_transcript();

    while (text_q.size() != 0) @(negedge clk);
    send_idle = 0;
    recv_idle = 0;
    while (items_added < 360) add_random_transcript();
    repeat (20) @(posedge clk);
    hold_start <= 1'b1;
    @(posedge clk);
    hold_start <= 1'b0;

    while (text_q.size() != 0 || s_tvalid || token_q.size() != 0) @(negedge clk);
    repeat (50) @(negedge clk);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
